@@ src/kdt_pkg.sv @@
`default_nettype none

package kdt_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);

    localparam int KEY_W      = 32;
    localparam int PAY_W      = 64;
    localparam int ID_W       = 16;
    localparam int COUNT_W    = 16;
    localparam int FIRST_ID_W = 15;

    localparam logic [FIRST_ID_W-1:0] FIRST_ID_RST = FIRST_ID_W'(1);
    localparam logic [COUNT_W-1:0]    COUNT_MAX    = '1;
    localparam logic [COUNT_W-1:0]    COUNT_ONE    = COUNT_W'(1);

    typedef enum logic [0:0] {
        CMD_ADD  = 1'b0,
        CMD_FIND = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NEW      = 3'd0,
        ST_REPEAT   = 3'd1,
        ST_CONFLICT = 3'd2,
        ST_FULL     = 3'd3,
        ST_FOUND    = 3'd4,
        ST_ABSENT   = 3'd5
    } t_status;

    typedef struct packed {
        t_cmd                     command;
        logic signed [KEY_W-1:0]  key;
        logic signed [PAY_W-1:0]  payload;
    } t_in_item;

    typedef struct packed {
        t_status              status;
        logic [ID_W-1:0]      id;
        logic [COUNT_W-1:0]   count;
    } t_out_item;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
    } t_row;

    typedef struct packed {
        logic load_item;
        logic scan_clr;
        logic scan_step;
        logic finish;
    } t_ctl_cmd;

    typedef struct packed {
        logic hit;
        logic done;
    } t_dp_stat;

endpackage

`default_nettype wire

@@ src/kdt_ram.sv @@
`default_nettype none

module kdt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ src/kdt_datapath.sv @@
`default_nettype none

module kdt_datapath import kdt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_item              i_in_data,
    input  logic                  i_cfg_valid,
    input  logic [FIRST_ID_W-1:0] i_cfg_data,
    input  t_ctl_cmd              i_cmd,
    output t_dp_stat              o_stat,
    output t_out_item             o_out_data
);

    t_in_item           r_item;
    logic [ID_W-1:0]    r_next_id;
    logic [CNT_W-1:0]   r_used;
    logic [CNT_W-1:0]   r_idx;
    logic               r_pend;
    logic [IDX_W-1:0]   r_pidx;
    t_out_item          r_out;
    t_out_item          n_out;

    logic               rd_en;
    logic [$bits(t_row)-1:0] rd_bits;
    t_row               rd_row;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    t_row               wr_row;
    logic               new_ins;
    logic               key_match;
    logic               pay_eq;
    logic               full;
    logic [COUNT_W-1:0] cnt_inc;

    kdt_ram #(
        .WIDTH ($bits(t_row)),
        .DEPTH (TABLE_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_row),
        .i_rd_en   (rd_en),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (rd_bits)
    );

    assign rd_row    = t_row'(rd_bits);
    assign rd_en     = i_cmd.scan_step && (r_idx < r_used);
    assign key_match = r_pend && (rd_row.key == $unsigned(r_item.key));
    assign pay_eq    = (rd_row.payload == $unsigned(r_item.payload));
    assign full      = (r_used == CNT_W'(TABLE_ENTRIES));
    assign cnt_inc   = (rd_row.count == COUNT_MAX) ? rd_row.count
                                                   : COUNT_W'(rd_row.count + 1'b1);

    assign o_stat.hit  = key_match;
    assign o_stat.done = !r_pend && (r_idx == r_used);

    always_comb begin
        n_out        = '0;
        n_out.status = ST_ABSENT;
        wr_en        = 1'b0;
        wr_addr      = r_pidx;
        wr_row       = rd_row;
        new_ins      = 1'b0;
        if (r_item.command == CMD_FIND) begin
            if (key_match) begin
                n_out.status = ST_FOUND;
                n_out.id     = rd_row.id;
                n_out.count  = rd_row.count;
            end
        end else if (key_match) begin
            n_out.id = rd_row.id;
            if (pay_eq) begin
                n_out.status = ST_REPEAT;
                n_out.count  = cnt_inc;
                wr_row.count = cnt_inc;
                wr_en        = i_cmd.finish;
            end else begin
                n_out.status = ST_CONFLICT;
                n_out.count  = rd_row.count;
            end
        end else if (full) begin
            n_out.status = ST_FULL;
        end else begin
            n_out.status   = ST_NEW;
            n_out.id       = r_next_id;
            n_out.count    = COUNT_ONE;
            wr_addr        = r_used[IDX_W-1:0];
            wr_row.key     = $unsigned(r_item.key);
            wr_row.payload = $unsigned(r_item.payload);
            wr_row.id      = r_next_id;
            wr_row.count   = COUNT_ONE;
            wr_en          = i_cmd.finish;
            new_ins        = i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_id <= ID_W'(FIRST_ID_RST);
            r_used    <= '0;
            r_idx     <= '0;
            r_pend    <= 1'b0;
        end else begin
            if (new_ins) begin
                r_next_id <= ID_W'(r_next_id + 1'b1);
                r_used    <= CNT_W'(r_used + 1'b1);
            end else if (i_cfg_valid && (r_used == '0)) begin
                r_next_id <= ID_W'(i_cfg_data);
            end
            if (i_cmd.scan_clr) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan_step) begin
                if (rd_en) begin
                    r_idx  <= CNT_W'(r_idx + 1'b1);
                    r_pend <= 1'b1;
                end else begin
                    r_pend <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
        if (i_cmd.scan_step && rd_en) begin
            r_pidx <= r_idx[IDX_W-1:0];
        end
        if (i_cmd.finish) begin
            r_out <= n_out;
        end
    end

    assign o_out_data = r_out;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CNT_W'(TABLE_ENTRIES))
        else $error("fill count beyond table size");

    a_pend_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> ({1'b0, r_pidx} < r_used))
        else $error("compare on an unfilled entry");

    a_insert_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        new_ins |=> (r_used == CNT_W'($past(r_used) + 1'b1)))
        else $error("insert did not bump fill count");

endmodule

`default_nettype wire

@@ src/kdt_ctrl.sv @@
`default_nettype none

module kdt_ctrl import kdt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    input  t_dp_stat i_stat,
    output t_ctl_cmd o_cmd
);

    typedef enum logic [0:0] {
        S_IDLE,
        S_SCAN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_item = 1'b1;
                    o_cmd.scan_clr  = 1'b1;
                    n_state         = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_stat.hit || i_stat.done) begin
                    if (out_free) begin
                        o_cmd.finish = 1'b1;
                        n_out_valid  = 1'b1;
                        n_state      = S_IDLE;
                    end
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote an untaken beat");

    a_finish_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.finish |=> r_out_valid)
        else $error("finished result not presented");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.finish))
        else $error("output valid without a finished item");

endmodule

`default_nettype wire

@@ src/key_dedup_id_table_core.sv @@
`default_nettype none

// Each item is compared against the filled entries in order, one entry per cycle through the
// single read port of the entry memory; a hit stops the scan, a miss or full scans every entry.
// One item at a time: no new item is taken until the result of the last one has been registered,
// and that result also waits while the previous output beat has not been taken.
// Reset: synchronous active low; clears fill count, scan and handshake state, next id = 1.
// The entry memory is not cleared; entries are filled in order and read only below the fill count.

module key_dedup_id_table_core import kdt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [FIRST_ID_W-1:0] i_cfg_data
);

    t_ctl_cmd cmd;
    t_dp_stat stat;

    assign o_cfg_ready = 1'b1;

    kdt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    kdt_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire

@@ sim/key_dedup_id_table_core_tb.sv @@
`timescale 1ns / 100ps

module key_dedup_id_table_core_tb;
    import kdt_pkg::*;

    localparam int SETTLE_CYCLES = 70;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int POOL_SIZE     = 80;
    localparam int MAX_PRINTS    = 20;

    typedef struct packed {
        t_cmd               command;
        logic [KEY_W-1:0]   key;
        logic [PAY_W-1:0]   payload;
        logic               typed;
        t_status            status;
        logic [ID_W-1:0]    id;
        logic [COUNT_W-1:0] count;
    } t_vector;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_data   = '0;
    logic                  i_out_ready = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic [FIRST_ID_W-1:0] i_cfg_data  = '0;
    logic                  o_in_ready;
    logic                  o_out_valid;
    logic                  o_cfg_ready;
    t_out_item             o_out_data;

    // key/payload pool: repeats, conflicts and more keys than entries
    logic [KEY_W-1:0]      pool_key [POOL_SIZE];
    logic [PAY_W-1:0]      pool_pay [POOL_SIZE];

    // predicted table contents
    logic [KEY_W-1:0]      stored_key [TABLE_ENTRIES];
    logic [PAY_W-1:0]      stored_pay [TABLE_ENTRIES];
    logic [ID_W-1:0]       stored_id  [TABLE_ENTRIES];
    logic [COUNT_W-1:0]    stored_cnt [TABLE_ENTRIES];
    int                    stored_used  = 0;
    logic [ID_W-1:0]       id_next      = ID_W'(1);

    t_out_item             pending_results [$];
    t_out_item             expected_beat;
    int                    mismatch_count = 0;
    int                    stall_cycles   = 0;
    int                    in_idle_pct    = 0;
    int                    out_stall_pct  = 0;
    logic                  hold_off       = 1'b0;

    t_vector directed_rows [17] = '{
        '{CMD_FIND, 32'h0000_0000, 64'h0, 1'b1, ST_ABSENT, 16'h0000, 16'd0},
        '{CMD_ADD,  32'h8000_0000, 64'h8000_0000_0000_0000, 1'b1, ST_NEW, 16'h7FFF, 16'd1},
        '{CMD_ADD,  32'h7FFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, ST_NEW, 16'h8000, 16'd1},
        '{CMD_ADD,  32'h8000_0000, 64'h8000_0000_0000_0000, 1'b1, ST_REPEAT, 16'h7FFF, 16'd2},
        '{CMD_ADD,  32'h8000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, ST_CONFLICT, 16'h7FFF, 16'd2},
        '{CMD_FIND, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_FOUND, 16'h7FFF, 16'd2},
        '{CMD_FIND, 32'h7FFF_FFFF, 64'h0, 1'b1, ST_FOUND, 16'h8000, 16'd1},
        '{CMD_ADD,  32'h0000_0000, 64'h0, 1'b1, ST_NEW, 16'h8001, 16'd1},
        '{CMD_ADD,  32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_NEW, 16'h8002, 16'd1},
        '{CMD_ADD,  32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_CONFLICT, 16'h8001, 16'd1},
        '{CMD_ADD,  32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_REPEAT, 16'h8002, 16'd2},
        '{CMD_FIND, 32'h8000_0001, 64'h0, 1'b1, ST_ABSENT, 16'h0000, 16'd0},
        '{CMD_FIND, 32'h0000_0000, 64'h0, 1'b1, ST_FOUND, 16'h8001, 16'd1},
        '{CMD_ADD,  32'h7FFF_FFFE, 64'h0123_4567_89AB_CDEF, 1'b0, ST_NEW, 16'h0, 16'd0},
        '{CMD_ADD,  32'h7FFF_FFFE, 64'h0123_4567_89AB_CDEF, 1'b0, ST_NEW, 16'h0, 16'd0},
        '{CMD_ADD,  32'h0000_0001, 64'h0000_0000_0000_0001, 1'b0, ST_NEW, 16'h0, 16'd0},
        '{CMD_FIND, 32'h0000_0001, 64'h0, 1'b0, ST_NEW, 16'h0, 16'd0}
    };

    key_dedup_id_table_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_out_item dedup_outcome(input t_in_item item);
        t_out_item res;
        int        hit;
        hit = -1;
        res = '0;
        for (int e = 0; e < stored_used; e++) begin
            if (hit < 0 && stored_key[e] == item.key) hit = e;
        end
        if (item.command == CMD_FIND) begin
            if (hit >= 0) begin
                res.status = ST_FOUND;
                res.id     = stored_id[hit];
                res.count  = stored_cnt[hit];
            end else begin
                res.status = ST_ABSENT;
            end
        end else if (hit >= 0) begin
            if (stored_pay[hit] == item.payload) begin
                if (stored_cnt[hit] != COUNT_MAX) stored_cnt[hit] = stored_cnt[hit] + 1'b1;
                res.status = ST_REPEAT;
            end else begin
                res.status = ST_CONFLICT;
            end
            res.id    = stored_id[hit];
            res.count = stored_cnt[hit];
        end else if (stored_used >= TABLE_ENTRIES) begin
            res.status = ST_FULL;
        end else begin
            stored_key[stored_used] = item.key;
            stored_pay[stored_used] = item.payload;
            stored_id[stored_used]  = id_next;
            stored_cnt[stored_used] = COUNT_ONE;
            res.status = ST_NEW;
            res.id     = id_next;
            res.count  = COUNT_ONE;
            id_next     = id_next + 1'b1;
            stored_used = stored_used + 1;
        end
        return res;
    endfunction

    function automatic t_in_item random_item();
        t_in_item item;
        int       k;
        k = $urandom_range(POOL_SIZE - 1);
        item.command = ($urandom_range(99) < 30) ? CMD_FIND : CMD_ADD;
        item.key     = ($urandom_range(99) < 10) ? $urandom : pool_key[k];
        item.payload = ($urandom_range(99) < 25) ? {$urandom, $urandom} : pool_pay[k];
        return item;
    endfunction

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        if (mismatch_count < MAX_PRINTS) begin
            $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
        end
        mismatch_count++;
    endtask

    // called right after the clock rises; returns once the input handshake has taken the item
    task automatic send_item(input t_in_item item, input bit typed, input t_out_item typed_res);
        t_out_item res;
        if (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < in_idle_pct);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        res = dedup_outcome(item);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic cfg_write(input logic [FIRST_ID_W-1:0] value, input bit keep_valid);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (!keep_valid) i_cfg_valid <= 1'b0;
        if (stored_used == 0) id_next = {1'b0, value};
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int n, input int idle_pct, input int stall_pct);
        in_idle_pct    = idle_pct;
        out_stall_pct <= stall_pct;
        repeat (n) send_item(random_item(), 1'b0, '0);
        drain();
    endtask

    always @(posedge i_clk) begin
        i_out_ready <= !hold_off && ($urandom_range(99) >= out_stall_pct);
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unrequested beat, id", o_out_data.id, 16'd0);
            end else begin
                expected_beat = pending_results.pop_front();
                if (o_out_data.status !== expected_beat.status) begin
                    report_mismatch("status", 16'(o_out_data.status), 16'(expected_beat.status));
                end
                if (o_out_data.id !== expected_beat.id) begin
                    report_mismatch("id", o_out_data.id, expected_beat.id);
                end
                if (o_out_data.count !== expected_beat.count) begin
                    report_mismatch("count", o_out_data.count, expected_beat.count);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        for (int p = 0; p < POOL_SIZE; p++) begin
            pool_key[p] = $urandom;
            pool_pay[p] = {$urandom, $urandom};
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // both extremes while empty; the last one seeds the ids
        cfg_write(15'd0, 1'b1);
        cfg_write(15'h7FFF, 1'b0);

        foreach (directed_rows[r]) begin
            send_item('{directed_rows[r].command, directed_rows[r].key, directed_rows[r].payload},
                      directed_rows[r].typed,
                      '{directed_rows[r].status, directed_rows[r].id, directed_rows[r].count});
        end
        drain();

        run_random(200, 0, 0);
        cfg_write(FIRST_ID_W'($urandom_range(1, 32766)), 1'b0);
        run_random(200, 70, 0);
        cfg_write(15'd0, 1'b0);
        run_random(200, 0, 70);

        // fill every entry, then a few fresh keys to hit the full case
        in_idle_pct    = 0;
        out_stall_pct <= 0;
        while (stored_used < TABLE_ENTRIES) begin
            send_item('{CMD_ADD, $urandom, {$urandom, $urandom}}, 1'b0, '0);
        end
        repeat (4) send_item('{CMD_ADD, $urandom, {$urandom, $urandom}}, 1'b0, '0);
        drain();
        cfg_write(15'h7FFF, 1'b0);

        fork
            begin
                hold_off <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_off <= 1'b0;
            end
        join_none
        run_random(250, 38, 38);

        if (mismatch_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
